// ===== rtl/core/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizing defaults, opcode and
// status codes, and the sequencer state type. No dependencies.
`default_nettype none
package ffha_pkg;
  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int MAX_SEGMENTS_DEF = 512;
  localparam int HEADER_BYTES_DEF = 9;
  localparam int SPLIT_SLACK      = 4;
  localparam int OFFSET_W         = 12;
  localparam int SIZE_W           = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,    // read request for the scan entry
    S_AWAIT,  // read data comes back
    S_ACHK,   // compare against request
    S_SHRD,   // shift-up read
    S_SHWAIT,
    S_SHWR,   // shift-up write
    S_SPLIT,  // write remainder and shrink
    S_FCHK,   // free search compare
    S_MRD,    // merge read
    S_MWAIT,
    S_MSTEP,  // merge compaction step
    S_MFLUSH, // write back last pending segment
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/ffha_table.sv =====
// Segment table memory: start, size and free flag per entry.
// Depends on ffha_pkg. One write port, one registered read port.
`default_nettype none
module ffha_table #(
  parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
  parameter int AW = $clog2(MAX_SEGMENTS),
  parameter int HW = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [HW-1:0] wstart,
  input  wire logic [HW-1:0] wsize,
  input  wire logic          wfree,
  input  wire logic [AW-1:0] raddr,
  output logic      [HW-1:0] rstart,
  output logic      [HW-1:0] rsize,
  output logic               rfree
);
  logic [2*HW:0] mem [MAX_SEGMENTS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wstart, wsize, wfree};
    {rstart, rsize, rfree} <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: sequencer, shared adder and
// compare, and the segment table. Depends on ffha_pkg and ffha_table.
//
//  channel | signals                                    | handshake
//  request | opcode, request_size, free_offset          | start & !busy
//  result  | alloc_offset, status                       | done strobe, one cycle
//
// A request scans the table through its single read port, segment by
// segment; a split also shifts the later entries up, and a free is followed
// by a merge pass over the whole table, so the worst case is a free of the
// last segment followed by a merge over the whole table.
// After reset the table holds one free segment covering the heap; only entry 0
// is written at reset by a one-cycle init step, during which busy is high.
// busy rises when the sequencer leaves idle after acceptance and stays high until the done strobe cycle ends.
// The receiver cannot stall; the result is shown for exactly one cycle.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          opcode,
  input  wire logic [ffha_pkg::SIZE_W-1:0]   request_size,
  input  wire logic [ffha_pkg::OFFSET_W-1:0] free_offset,
  output logic                               done,
  output logic [ffha_pkg::OFFSET_W-1:0]      alloc_offset,
  output logic [1:0]                         status
);
  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  // Holds heap offsets and sizes, plus headroom for header sums.
  localparam int HW = $clog2(HEAP_BYTES) + 2;
  localparam logic [HW-1:0] HDR = HW'(HEADER_BYTES);
  localparam logic [HW-1:0] SLACK = HW'(ffha_pkg::SPLIT_SLACK);

  ffha_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;     // scan / read index
  logic [CW-1:0] widx, widx_next;   // merge write index
  logic          init, init_next;
  logic          op;
  logic [HW-1:0] rsz;
  logic [ffha_pkg::OFFSET_W-1:0] foff;
  // Segment under work (hit on alloc, pending segment on merge).
  logic [HW-1:0] cstart, cstart_next, csize, csize_next;
  logic          cfree, cfree_next;
  logic [CW-1:0] hit, hit_next;
  logic          have, have_next;   // merge: a pending segment exists
  logic [ffha_pkg::OFFSET_W-1:0] res_off, res_off_next;
  logic [1:0]    res_st, res_st_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] wstart, wsize, rstart, rsize;
  logic          wfree, rfree;

  // Shared arithmetic unit: one adder and one compare.
  logic [HW-1:0] add_a, add_b, add_y;
  logic          cmp_gt;
  assign add_y  = add_a + add_b;

  ffha_table #(.MAX_SEGMENTS(MAX_SEGMENTS), .AW(AW), .HW(HW)) u_table (
    .clk, .we, .waddr, .wstart, .wsize, .wfree,
    .raddr, .rstart, .rsize, .rfree
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_IDLE;
      count <= CW'(1);
      init  <= 1'b1;
      idx   <= '0;
      widx  <= '0;
      have  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      init  <= init_next;
      idx   <= idx_next;
      widx  <= widx_next;
      have  <= have_next;
    end
    cstart  <= cstart_next;
    csize   <= csize_next;
    cfree   <= cfree_next;
    hit     <= hit_next;
    res_off <= res_off_next;
    res_st  <= res_st_next;
    if (start && !busy) begin
      op   <= opcode;
      rsz  <= HW'(request_size);
      foff <= free_offset;
    end
  end

  assign busy = init || (state != ffha_pkg::S_IDLE);

  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    widx_next    = widx;
    init_next    = 1'b0;
    cstart_next  = cstart;
    csize_next   = csize;
    cfree_next   = cfree;
    hit_next     = hit;
    have_next    = have;
    res_off_next = res_off;
    res_st_next  = res_st;
    we     = 1'b0;
    waddr  = idx[AW-1:0];
    wstart = cstart;
    wsize  = csize;
    wfree  = cfree;
    raddr  = idx[AW-1:0];
    add_a  = '0;
    add_b  = '0;
    cmp_gt = 1'b0;
    done   = 1'b0;
    if (init) begin
      we = 1'b1;
      waddr = '0;
      wstart = '0;
      wsize = HW'(HEAP_BYTES - HEADER_BYTES);
      wfree = 1'b1;
    end
    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (start && !busy) begin
          idx_next = '0;
          state_next = ffha_pkg::S_ARD;
        end
      end
      ffha_pkg::S_ARD: begin
        if (idx >= count) begin
          res_off_next = '0;
          res_st_next = (op == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NOMEM
                                                   : ffha_pkg::ST_BADFREE;
          state_next = ffha_pkg::S_DONE;
        end else if (op == ffha_pkg::OP_FREE && foff == '0) begin
          res_off_next = '0;
          res_st_next = ffha_pkg::ST_OK;
          state_next = ffha_pkg::S_DONE;
        end else begin
          state_next = ffha_pkg::S_AWAIT;
        end
      end
      ffha_pkg::S_AWAIT: begin
        cstart_next = rstart;
        csize_next  = rsize;
        cfree_next  = rfree;
        hit_next    = idx;
        state_next  = (op == ffha_pkg::OP_ALLOC) ? ffha_pkg::S_ACHK : ffha_pkg::S_FCHK;
      end
      ffha_pkg::S_ACHK: begin
        // Split threshold: size + header + slack.
        add_a = rsz;
        add_b = HDR + SLACK;
        cmp_gt = csize > add_y;
        if (cfree && csize >= rsz) begin
          res_off_next = ffha_pkg::OFFSET_W'(cstart + HDR);
          res_st_next = ffha_pkg::ST_OK;
          if (cmp_gt && count < CW'(MAX_SEGMENTS)) begin
            idx_next = count;
            state_next = ffha_pkg::S_SHRD;
          end else begin
            we = 1'b1; waddr = hit[AW-1:0]; wfree = 1'b0;
            state_next = ffha_pkg::S_DONE;
          end
        end else begin
          idx_next = idx + CW'(1);
          state_next = ffha_pkg::S_ARD;
        end
      end
      ffha_pkg::S_SHRD: begin
        if (idx == hit + CW'(1)) begin
          state_next = ffha_pkg::S_SPLIT;
        end else begin
          raddr = AW'(idx - CW'(1));
          state_next = ffha_pkg::S_SHWAIT;
        end
      end
      ffha_pkg::S_SHWAIT: begin
        raddr = AW'(idx - CW'(1));
        state_next = ffha_pkg::S_SHWR;
      end
      ffha_pkg::S_SHWR: begin
        we = 1'b1; wstart = rstart; wsize = rsize; wfree = rfree;
        idx_next = idx - CW'(1);
        state_next = ffha_pkg::S_SHRD;
      end
      ffha_pkg::S_SPLIT: begin
        // Remainder entry at hit+1, then shrink the granted one next cycle.
        add_a = cstart; add_b = HDR + rsz;
        we = 1'b1; waddr = AW'(hit + CW'(1));
        wstart = add_y; wsize = csize - rsz - HDR; wfree = 1'b1;
        csize_next = rsz; cfree_next = 1'b0;
        count_next = count + CW'(1);
        state_next = ffha_pkg::S_MFLUSH;
        widx_next = hit;
        have_next = 1'b0;
      end
      ffha_pkg::S_FCHK: begin
        add_a = cstart; add_b = HDR;
        if (add_y == HW'(foff)) begin
          we = 1'b1; waddr = hit[AW-1:0]; wfree = 1'b1;
          res_off_next = '0; res_st_next = ffha_pkg::ST_OK;
          idx_next = '0; widx_next = '0; have_next = 1'b0;
          state_next = ffha_pkg::S_MRD;
        end else begin
          idx_next = idx + CW'(1);
          state_next = ffha_pkg::S_ARD;
        end
      end
      ffha_pkg::S_MRD: begin
        if (idx >= count) begin
          state_next = ffha_pkg::S_MFLUSH;
        end else begin
          state_next = ffha_pkg::S_MWAIT;
        end
      end
      ffha_pkg::S_MWAIT: state_next = ffha_pkg::S_MSTEP;
      ffha_pkg::S_MSTEP: begin
        add_a = csize; add_b = HDR + rsize;
        if (have && cfree && rfree) begin
          csize_next = add_y;
        end else begin
          if (have) begin
            we = 1'b1; waddr = widx[AW-1:0];
            widx_next = widx + CW'(1);
          end
          cstart_next = rstart; csize_next = rsize; cfree_next = rfree;
          have_next = 1'b1;
        end
        idx_next = idx + CW'(1);
        state_next = ffha_pkg::S_MRD;
      end
      ffha_pkg::S_MFLUSH: begin
        we = 1'b1; waddr = widx[AW-1:0];
        if (op == ffha_pkg::OP_FREE) count_next = widx + CW'(1);
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        done = 1'b1;
        state_next = ffha_pkg::S_IDLE;
      end
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

  assign alloc_offset = res_off;
  assign status = res_st;

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done strobe lasted more than one cycle");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CW'(MAX_SEGMENTS)) else $error("segment count out of range");
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("undefined status code");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result without busy");
endmodule
`default_nettype wire
